// ===== design/cmd3_pkg.sv =====
// Shared constants, types and helper functions for the clock multiplier/divider.
package cmd3_pkg;

  // Tick counter width and sync window
  localparam int CNT_W  = 32;
  localparam int STEP_W = $clog2(CNT_W);
  localparam int SYNC_WIN = 5;

  // Channel count and channel index width
  localparam int NCH  = 3;
  localparam int CH_W = 2;

  // Field widths
  localparam int MV_W   = 15;
  localparam int IDX_W  = 4;
  localparam int RATE_W = 3;
  localparam int PLEN_W = 16;

  // Port widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Schmitt thresholds in millivolts
  localparam logic signed [MV_W-1:0] MV_HIGH = 15'sd1700;
  localparam logic signed [MV_W-1:0] MV_LOW  = 15'sd200;

  // Rate index codes
  localparam logic [IDX_W-1:0] IDX_UNITY = 4'd5;
  localparam logic [IDX_W-1:0] IDX_MAX   = 4'd10;

  // Reset values of the registers
  localparam logic [IDX_W-1:0]  RATE_RST = 4'd5;
  localparam logic [PLEN_W-1:0] PLEN_RST = 16'd5;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RATE_FIRST,
    REG_RATE_SECOND,
    REG_RATE_THIRD,
    REG_PULSE_LEN
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOCK,
    S_EDGE,
    S_TGT_GO,
    S_TGT_WAIT,
    S_SCHED,
    S_DONE
  } state_t;

  // Request to the shared target unit
  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] idx;
  } tgt_req_t;

  // Response from the shared target unit
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] target;
  } tgt_rsp_t;

  // Rate indexes above ten behave as ten
  function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] idx);
    clamp_idx = (idx > IDX_MAX) ? IDX_MAX : idx;
  endfunction

  // Multiply/divide factor for a clamped rate index
  function automatic logic [RATE_W-1:0] rate_of(input logic [IDX_W-1:0] idx);
    unique case (idx) inside
      4'd0, 4'd10: rate_of = 3'd6;
      4'd1, 4'd9:  rate_of = 3'd5;
      4'd2, 4'd8:  rate_of = 3'd4;
      4'd3, 4'd7:  rate_of = 3'd3;
      4'd4, 4'd6:  rate_of = 3'd2;
      default:     rate_of = 3'd1;
    endcase
  endfunction

endpackage

// ===== design/cmd3_tgt_unit.sv =====
// Shared pulse interval unit: period times rate registered directly, period over rate bit-serially.
module cmd3_tgt_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [cmd3_pkg::CNT_W-1:0] period,
  input  cmd3_pkg::tgt_req_t      req,
  output cmd3_pkg::tgt_rsp_t      rsp
);
  import cmd3_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [CNT_W-1:0]  q_r;
  logic [RATE_W-1:0] rem_r;
  logic [RATE_W-1:0] div_r;

  logic [RATE_W-1:0]  req_rate;
  logic [CNT_W-1:0]   prod;
  logic [RATE_W:0]    rem_s;
  logic               qbit;
  logic [RATE_W:0]    rem_d;

  // Factor for the requested index, and product for the divide and unity indexes, wrapping at the counter width
  assign req_rate = rate_of(req.idx);
  assign prod     = period * CNT_W'(req_rate);

  // One restoring division step
  assign rem_s = {rem_r, q_r[CNT_W-1]};
  assign qbit  = (rem_s >= {1'b0, div_r});
  assign rem_d = rem_s - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (req.idx < IDX_UNITY) begin
          // Multiplier channel: divide the period by the factor
          busy_r <= 1'b1;
          q_r    <= period;
          rem_r  <= '0;
          div_r  <= req_rate;
          cnt_r  <= STEP_W'(CNT_W - 1);
        end else begin
          // Divider or unity channel: scale the period
          q_r    <= prod;
          done_r <= 1'b1;
        end
      end else if (busy_r) begin
        q_r   <= {q_r[CNT_W-2:0], qbit};
        rem_r <= qbit ? rem_d[RATE_W-1:0] : rem_s[RATE_W-1:0];
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done_r;
  assign rsp.target = q_r;

endmodule

// ===== design/clock_mult_div_three_channel.sv =====
// Three-channel clock multiplier/divider: edge tracking, sync, pulse scheduling.
// Locked item: accept (S_IDLE), clock handling (S_CLOCK, S_EDGE), channel scan (S_SCHED),
// result (S_DONE); the next item is accepted only back in S_IDLE; unlocked items skip the scan.
// A new lock, or the first locked item after a rate write, first recomputes three
// intervals through S_TGT_GO and S_TGT_WAIT: a scaled period per unity/divide channel,
// a bit-serial divide per multiply channel. A waiting result holds the next item
// in its result step; synchronous active-low reset restores defaults, clears timing.
module clock_mult_div_three_channel (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // clock_connected, clock_mv[14:0], skip_first, skip_second, skip_third,
  // mute_button_first, mute_button_second, mute_button_third, pad
  input  logic [cmd3_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // gate_first, gate_second, gate_third, in_sync,
  // muted_first, muted_second, muted_third, pad
  output logic [cmd3_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_we,
  input  logic [cmd3_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [cmd3_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import cmd3_pkg::*;

  localparam logic [CNT_W-1:0] WIN_LO = CNT_W'(SYNC_WIN);
  localparam logic [CNT_W-1:0] WIN_HI = CNT_W'(0) - CNT_W'(SYNC_WIN);

  state_t state_r, state_nxt;

  // Configuration
  logic [IDX_W-1:0]  rate_idx_r [NCH];
  logic [PLEN_W-1:0] plen_r;

  // Clock tracking
  logic [CNT_W-1:0] tick_r;
  logic [CNT_W-1:0] last_edge_r;
  logic [CNT_W-1:0] period_r;
  logic [CNT_W-1:0] diff_r;
  logic             locked_r;
  logic             clk_hi_r;
  logic             edge_seen_r;
  logic             edge_r;
  logic             dirty_r;

  // Channels
  logic [CNT_W-1:0]  anchor_r [NCH];
  logic [CNT_W-1:0]  target_r [NCH];
  logic [PLEN_W-1:0] prem_r   [NCH];
  logic [NCH-1:0]    muted_r;
  logic [NCH-1:0]    btn_hi_r;
  logic [CH_W-1:0]   ch_r;

  // Captured transaction
  logic                   conn_r;
  logic signed [MV_W-1:0] mv_r;
  logic [NCH-1:0]         skip_r;

  // Result register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Input field views
  logic                   in_conn;
  logic signed [MV_W-1:0] in_mv;
  logic [NCH-1:0]         in_skip;
  logic [NCH-1:0]         in_btn;
  logic                   in_acc;

  assign in_conn = in_tdata[0];
  assign in_mv   = in_tdata[MV_W:1];
  assign in_skip = in_tdata[MV_W+NCH:MV_W+1];
  assign in_btn  = in_tdata[MV_W+2*NCH:MV_W+NCH+1];
  assign in_acc  = in_tvalid && in_tready;

  // Edge window and lock decision
  logic [CNT_W-1:0] dev;
  logic             win_in;
  logic             new_lock;
  logic             locked_after;

  assign dev      = diff_r - period_r;
  assign win_in   = (dev < WIN_LO) || ((dev > WIN_HI) && dev[CNT_W-1]);
  assign new_lock = edge_r && !locked_r && edge_seen_r;

  always_comb begin
    locked_after = locked_r;
    if (edge_r) begin
      if (locked_r) begin
        locked_after = win_in;
      end else if (edge_seen_r) begin
        locked_after = 1'b1;
      end
    end
  end

  // Scan compare for the channel under ch_r
  logic sched_hit;
  assign sched_hit = ((anchor_r[ch_r] + target_r[ch_r]) == tick_r);

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  logic last_ch;
  assign last_ch = (ch_r == CH_W'(NCH - 1));

  // Shared interval unit
  tgt_req_t tgt_req;
  tgt_rsp_t tgt_rsp;

  cmd3_tgt_unit u_tgt (
    .clk    (clk),
    .rst_n  (rst_n),
    .period (period_r),
    .req    (tgt_req),
    .rsp    (tgt_rsp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_CLOCK;
      S_CLOCK: state_nxt = S_EDGE;
      S_EDGE: begin
        if (!locked_after) begin
          state_nxt = S_DONE;
        end else if (dirty_r || new_lock) begin
          state_nxt = S_TGT_GO;
        end else begin
          state_nxt = S_SCHED;
        end
      end
      S_TGT_GO:   state_nxt = S_TGT_WAIT;
      S_TGT_WAIT: if (tgt_rsp.done) state_nxt = last_ch ? S_SCHED : S_TGT_GO;
      S_SCHED:    if (last_ch) state_nxt = S_DONE;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready     = 1'b0;
    tgt_req.start = 1'b0;
    tgt_req.idx   = clamp_idx(rate_idx_r[ch_r]);
    unique case (state_r)
      S_IDLE:   in_tready = 1'b1;
      S_TGT_GO: tgt_req.start = 1'b1;
      default: begin
        in_tready     = 1'b0;
        tgt_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath and timing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCH; c++) begin
        rate_idx_r[c] <= RATE_RST;
        anchor_r[c]   <= '0;
        prem_r[c]     <= '0;
      end
      plen_r      <= PLEN_RST;
      tick_r      <= '0;
      last_edge_r <= '0;
      period_r    <= '0;
      locked_r    <= 1'b0;
      clk_hi_r    <= 1'b0;
      edge_seen_r <= 1'b0;
      edge_r      <= 1'b0;
      dirty_r     <= 1'b1;
      muted_r     <= '0;
      btn_hi_r    <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Result taken; a new one loads in S_DONE
      if (out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        // Capture the transaction, toggle mutes, advance the tick
        S_IDLE: begin
          if (in_acc) begin
            conn_r   <= in_conn;
            mv_r     <= in_mv;
            skip_r   <= in_skip;
            tick_r   <= tick_r + 1'b1;
            btn_hi_r <= in_btn;
            muted_r  <= muted_r ^ (in_btn & ~btn_hi_r);
          end
        end

        // Schmitt trigger on the clock, edge distance; a disconnect drops the lock
        S_CLOCK: begin
          diff_r <= tick_r - last_edge_r;
          edge_r <= conn_r && !clk_hi_r && (mv_r >= MV_HIGH);
          if (conn_r) begin
            if (clk_hi_r) begin
              if (mv_r <= MV_LOW) clk_hi_r <= 1'b0;
            end else if (mv_r >= MV_HIGH) begin
              clk_hi_r <= 1'b1;
            end
          end else begin
            locked_r    <= 1'b0;
            edge_seen_r <= 1'b0;
            last_edge_r <= '0;
          end
        end

        // Edge: first sighting, lock, realign, or loss of sync
        S_EDGE: begin
          ch_r <= '0;
          if (edge_r) begin
            last_edge_r <= tick_r;
            locked_r    <= locked_after;
            if (locked_r) begin
              if (win_in) begin
                for (int c = 0; c < NCH; c++) begin
                  if (clamp_idx(rate_idx_r[c]) < IDX_UNITY) begin
                    anchor_r[c] <= tick_r;
                    if (!skip_r[c] && (plen_r > prem_r[c])) prem_r[c] <= plen_r;
                  end
                end
              end
            end else if (!edge_seen_r) begin
              edge_seen_r <= 1'b1;
            end else begin
              period_r <= diff_r;
              dirty_r  <= 1'b1;
              for (int c = 0; c < NCH; c++) begin
                anchor_r[c] <= tick_r;
              end
            end
          end
        end

        // Collect one interval from the shared unit
        S_TGT_WAIT: begin
          if (tgt_rsp.done) begin
            target_r[ch_r] <= tgt_rsp.target;
            if (last_ch) begin
              ch_r    <= '0;
              dirty_r <= 1'b0;
            end else begin
              ch_r <= ch_r + 1'b1;
            end
          end
        end

        // Scheduled pulse check, one channel per cycle
        S_SCHED: begin
          if (sched_hit) begin
            anchor_r[ch_r] <= tick_r;
            if (!skip_r[ch_r] && (plen_r > prem_r[ch_r])) prem_r[ch_r] <= plen_r;
          end
          ch_r <= last_ch ? '0 : ch_r + 1'b1;
        end

        // Count pulses down and load the result register
        S_DONE: begin
          if (out_free) begin
            for (int c = 0; c < NCH; c++) begin
              if (prem_r[c] != '0) prem_r[c] <= prem_r[c] - 1'b1;
              out_data_r[c] <= (prem_r[c] != '0) && !muted_r[c];
            end
            out_data_r[NCH]              <= locked_r;
            out_data_r[2*NCH:NCH+1]      <= muted_r;
            out_data_r[OUT_DATA_W-1]     <= 1'b0;
            out_valid_r                  <= 1'b1;
          end
        end

        default: begin
        end
      endcase

      // Register writes: the user must write only while idle; the block itself does not enforce it
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_RATE_FIRST, REG_RATE_SECOND, REG_RATE_THIRD: begin
            rate_idx_r[cfg_addr] <= cfg_wdata[IDX_W-1:0];
            dirty_r              <= 1'b1;
          end
          REG_PULSE_LEN: plen_r <= cfg_wdata[PLEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/cmd3_checker.sv =====
// Port-level checker for the clock multiplier/divider and its bind.
module cmd3_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cmd3_pkg::OUT_DATA_W-1:0] out_tdata
);
  import cmd3_pkg::*;

  // One transaction in flight: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a transaction is in flight");

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A muted channel never shows a gate
  a_mute_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[NCH + 1]) &&
                   !(out_tdata[1] && out_tdata[NCH + 2]) &&
                   !(out_tdata[2] && out_tdata[NCH + 3]))
    else $error("gate high on a muted channel");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind clock_mult_div_three_channel cmd3_checker u_cmd3_checker (.*);

// ===== tb/clock_mult_div_three_channel_tb.sv =====
// Self-checking testbench for the three-channel clock multiplier/divider stream block.
module clock_mult_div_three_channel_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cmd3_pkg::*;

  // One sample tick as it travels in in_tdata (connected flag in bit 0)
  typedef struct packed {
    logic [NCH-1:0]          mute_btn;
    logic [NCH-1:0]          skip;
    logic signed [MV_W-1:0]  mv;
    logic                    connected;
  } tick_in_t;

  // One result as it travels in out_tdata (gate_first in bit 0)
  typedef struct packed {
    logic [NCH-1:0] muted;
    logic           sync;
    logic [NCH-1:0] gate;
  } tick_out_t;

  localparam int STALL_CYCLES = 400;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_RATE_FIRST;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Idle rates in percent, receiver hold-off handshake
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_req = 0;
  int unsigned stall_ack = 0;
  int unsigned stall_left = 0;

  // Bookkeeping
  tick_out_t   pending_outputs [$];
  tick_out_t   check_want;
  tick_out_t   check_got;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned locks_seen = 0;
  int unsigned sync_losses = 0;
  logic [NCH-1:0] btn_level = '0;

  // Predictor state
  logic [CNT_W-1:0]  tick_now;
  logic [CNT_W-1:0]  prev_edge_at;
  logic [CNT_W-1:0]  period_ticks;
  logic [CNT_W-1:0]  anchor [NCH];
  logic [PLEN_W-1:0] pulse_left [NCH];
  logic [PLEN_W-1:0] gate_len;
  logic [IDX_W-1:0]  rate_sel [NCH];
  logic              sync_locked;
  logic              clk_hi;
  logic              edge_known;
  logic [NCH-1:0]    mute_on;
  logic [NCH-1:0]    btn_hi;

  clock_mult_div_three_channel i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic reset_model();
    for (int c = 0; c < NCH; c++) begin
      anchor[c]     = '0;
      pulse_left[c] = '0;
      rate_sel[c]   = RATE_RST;
    end
    gate_len     = PLEN_RST;
    tick_now     = '0;
    prev_edge_at = '0;
    period_ticks = '0;
    sync_locked  = 1'b0;
    clk_hi       = 1'b0;
    edge_known   = 1'b0;
    mute_on      = '0;
    btn_hi       = '0;
  endtask

  // Rate index with out-of-range codes folded onto the slowest divide
  function automatic logic [IDX_W-1:0] eff_rate(int c);
    return (rate_sel[c] > IDX_MAX) ? IDX_MAX : rate_sel[c];
  endfunction

  function automatic void arm_pulse(int c);
    if (gate_len > pulse_left[c]) pulse_left[c] = gate_len;
  endfunction

  // Advance the model by one tick and return the outputs of that tick
  function automatic tick_out_t predict_tick(tick_in_t t);
    tick_out_t        r;
    logic             edge_now;
    logic             win_ok;
    logic [CNT_W-1:0] edge_dev;
    logic [CNT_W-1:0] span;
    logic [CNT_W-1:0] win_lo;
    logic [IDX_W-1:0] idx;
    int unsigned      fac;
    win_lo = '0 - CNT_W'(SYNC_WIN);

    // Mute buttons toggle on a rising level
    for (int c = 0; c < NCH; c++) begin
      if (t.mute_btn[c] && !btn_hi[c]) mute_on[c] = ~mute_on[c];
      btn_hi[c] = t.mute_btn[c];
    end

    tick_now = tick_now + 1'b1;

    // Clock edge detection and sync tracking
    if (t.connected) begin
      edge_now = 1'b0;
      if (clk_hi) begin
        if (t.mv <= MV_LOW) clk_hi = 1'b0;
      end else if (t.mv >= MV_HIGH) begin
        clk_hi   = 1'b1;
        edge_now = 1'b1;
      end
      if (edge_now) begin
        if (sync_locked) begin
          edge_dev = tick_now - prev_edge_at - period_ticks;
          win_ok   = (edge_dev < CNT_W'(SYNC_WIN)) || (edge_dev > win_lo && edge_dev[CNT_W-1]);
          if (win_ok) begin
            // multiplier channels realign on every good edge
            for (int c = 0; c < NCH; c++) begin
              if (eff_rate(c) < IDX_UNITY) begin
                anchor[c] = tick_now;
                if (!t.skip[c]) arm_pulse(c);
              end
            end
          end else begin
            sync_locked = 1'b0;
            sync_losses++;
          end
          prev_edge_at = tick_now;
        end else if (!edge_known) begin
          prev_edge_at = tick_now;
          edge_known   = 1'b1;
        end else begin
          period_ticks = tick_now - prev_edge_at;
          sync_locked  = 1'b1;
          locks_seen++;
          for (int c = 0; c < NCH; c++) anchor[c] = tick_now;
          prev_edge_at = tick_now;
        end
      end
    end else begin
      if (sync_locked) sync_losses++;
      sync_locked  = 1'b0;
      edge_known   = 1'b0;
      prev_edge_at = '0;
    end

    // Scheduled pulses: multiply below unity index, divide above it
    if (sync_locked) begin
      for (int c = 0; c < NCH; c++) begin
        idx  = eff_rate(c);
        fac  = (idx <= IDX_UNITY) ? 6 - idx : idx - 4;
        span = (idx > IDX_UNITY) ? period_ticks * CNT_W'(fac) : period_ticks / CNT_W'(fac);
        if (anchor[c] + span == tick_now) begin
          anchor[c] = tick_now;
          if (!t.skip[c]) arm_pulse(c);
        end
      end
    end

    // Pulse countdown, gates masked by mute
    for (int c = 0; c < NCH; c++) begin
      r.gate[c] = 1'b0;
      if (pulse_left[c] != '0) begin
        pulse_left[c] = pulse_left[c] - 1'b1;
        r.gate[c]     = !mute_on[c];
      end
      r.muted[c] = mute_on[c];
    end
    r.sync = sync_locked;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------

  // out_tready: random idling, or a long hold-off on request
  always @(posedge clk) begin
    if (stall_req != stall_ack) begin
      stall_ack  <= stall_req;
      stall_left <= STALL_CYCLES;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, actual %0b", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_outputs.size() == 0) begin
        $error("result transaction with no prediction waiting: %0h", out_tdata);
        mismatches++;
      end else begin
        check_want = pending_outputs.pop_front();
        check_got  = out_tdata[$bits(tick_out_t)-1:0];
        check_field("gate_first",   check_want.gate[0],  check_got.gate[0]);
        check_field("gate_second",  check_want.gate[1],  check_got.gate[1]);
        check_field("gate_third",   check_want.gate[2],  check_got.gate[2]);
        check_field("in_sync",      check_want.sync,     check_got.sync);
        check_field("muted_first",  check_want.muted[0], check_got.muted[0]);
        check_field("muted_second", check_want.muted[1], check_got.muted[1]);
        check_field("muted_third",  check_want.muted[2], check_got.muted[2]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one tick, wait for its handshake, record the prediction
  task automatic send_tick(input tick_in_t t);
    int unsigned gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < 24) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - $bits(tick_in_t)){1'b0}}, t};
    do @(posedge clk); while (!in_tready);
    pending_outputs.push_back(predict_tick(t));
    items_sent++;
  endtask

  task automatic send_fields(input logic conn, input int mv, input logic [NCH-1:0] skip,
                             input logic [NCH-1:0] btn);
    tick_in_t t;
    t.connected = conn;
    t.mv        = MV_W'(mv);
    t.skip      = skip;
    t.mute_btn  = btn;
    send_tick(t);
  endtask

  // Stop offering and wait until every prediction has been matched
  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    @(posedge clk);
    case (r)
      REG_RATE_FIRST:  rate_sel[0] = v[IDX_W-1:0];
      REG_RATE_SECOND: rate_sel[1] = v[IDX_W-1:0];
      REG_RATE_THIRD:  rate_sel[2] = v[IDX_W-1:0];
      REG_PULSE_LEN:   gate_len    = v[PLEN_W-1:0];
      default: ;
    endcase
  endtask

  // Clock voltage: first tick of a level crosses its threshold, later ticks
  // may sit anywhere that keeps the trigger where it is
  function automatic logic signed [MV_W-1:0] clock_level(bit high, bit first);
    int v;
    if (high) v = first ? int'($urandom_range(16383, 1700)) : int'($urandom_range(16383, 201));
    else v = (first ? int'($urandom_range(16584)) : int'($urandom_range(18083))) - 16384;
    return MV_W'(v);
  endfunction

  // Square clock of the given period; jitter stays inside the sync window,
  // a slip lands just outside it or well past it
  task automatic run_clock(input int unsigned n_items, input int unsigned period,
                           input int unsigned jitter, input int unsigned slip_pct,
                           input int unsigned skip_pct);
    tick_in_t    t;
    int unsigned sent;
    int unsigned len;
    int unsigned hi_len;
    sent = 0;
    while (sent < n_items) begin
      len = period;
      if (jitter != 0) len = period - jitter + $urandom_range(2 * jitter);
      if (slip_pct != 0 && $urandom_range(99) < slip_pct)
        len = ($urandom_range(1) && period > 6) ? period - 5 : period + $urandom_range(12, 5);
      hi_len = (len + 1) / 2;
      for (int unsigned pos = 0; pos < len && sent < n_items; pos++) begin
        for (int c = 0; c < NCH; c++) begin
          if ($urandom_range(99) < 4) btn_level[c] = ~btn_level[c];
          t.skip[c] = ($urandom_range(99) < skip_pct);
        end
        t.connected = 1'b1;
        t.mute_btn  = btn_level;
        t.mv        = clock_level(pos < hi_len, pos == 0 || pos == hi_len);
        send_tick(t);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Thresholds, first edge, lock, window edges, skip, mute, unlock, disconnect
  task automatic test_directed_edges();
    send_fields(1'b0, 16383, 3'b111, 3'b000);
    send_fields(1'b1, -16384, 3'b000, 3'b000);
    send_fields(1'b1, 1699, 3'b000, 3'b000);
    send_fields(1'b1, 1700, 3'b000, 3'b001);
    send_fields(1'b1, 201, 3'b000, 3'b001);
    send_fields(1'b1, 200, 3'b000, 3'b000);
    send_fields(1'b1, -10000, 3'b000, 3'b000);
    send_fields(1'b1, 10000, 3'b000, 3'b010);
    send_fields(1'b1, 0, 3'b000, 3'b000);
    send_fields(1'b1, -1, 3'b000, 3'b100);
    send_fields(1'b1, 199, 3'b000, 3'b000);
    send_fields(1'b1, 1700, 3'b000, 3'b000);
    send_fields(1'b1, 200, 3'b000, 3'b001);
    send_fields(1'b1, 0, 3'b000, 3'b000);
    send_fields(1'b1, 1701, 3'b111, 3'b000);
    send_fields(1'b1, 1000, 3'b111, 3'b010);
    send_fields(1'b1, 100, 3'b000, 3'b000);
    // late edge, outside the window
    repeat (6) send_fields(1'b1, -5000, 3'b000, 3'b000);
    send_fields(1'b1, 5000, 3'b000, 3'b000);
    send_fields(1'b0, 5000, 3'b000, 3'b000);
    drain_outputs();
  endtask

  // Rate and pulse-length settings, each followed by a clock run without slips
  task automatic test_rate_settings(input int first, input int last);
    logic [IDX_W-1:0]  r1;
    logic [IDX_W-1:0]  r2;
    logic [IDX_W-1:0]  r3;
    logic [PLEN_W-1:0] plen;
    for (int k = first; k <= last; k++) begin
      case (k)
        0:       begin r1 = 4'd0;  r2 = 4'd5;  r3 = 4'd10; plen = 16'd1;     end
        1:       begin r1 = 4'd4;  r2 = 4'd6;  r3 = 4'd5;  plen = 16'd3;     end
        2:       begin r1 = 4'd1;  r2 = 4'd9;  r3 = 4'd2;  plen = 16'hFFFF;  end
        3:       begin r1 = 4'd3;  r2 = 4'd7;  r3 = 4'd8;  plen = 16'd0;     end
        4:       begin r1 = 4'd11; r2 = 4'd15; r3 = 4'd0;  plen = 16'd2;     end
        5:       begin r1 = 4'd2;  r2 = 4'd8;  r3 = 4'd12; plen = 16'd5;     end
        6:       begin r1 = 4'd10; r2 = 4'd10; r3 = 4'd10; plen = 16'd7;     end
        default: begin r1 = 4'd0;  r2 = 4'd0;  r3 = 4'd0;  plen = 16'd1;     end
      endcase
      write_reg(REG_RATE_FIRST, CFG_DATA_W'(r1));
      write_reg(REG_RATE_SECOND, CFG_DATA_W'(r2));
      write_reg(REG_RATE_THIRD, CFG_DATA_W'(r3));
      write_reg(REG_PULSE_LEN, CFG_DATA_W'(plen));
      cfg_we <= 1'b0;
      run_clock(65, $urandom_range(12, 6), ($urandom_range(1) != 0) ? 2 : 0, 0, 15);
      drain_outputs();
    end
  endtask

  // Jittered clock with occasional slips and short disconnects
  task automatic test_jitter_and_dropout();
    for (int k = 0; k < 5; k++) begin
      run_clock(16, $urandom_range(14, 8), 4, 15, 20);
      repeat ($urandom_range(3, 1))
        send_fields(1'b0, int'($urandom_range(32767)) - 16384, 3'($urandom), btn_level);
    end
    drain_outputs();
  endtask

  // Fastest clock, then unstructured noise on every field
  task automatic test_noise();
    run_clock(20, 2, 0, 0, 30);
    repeat (40)
      send_fields($urandom_range(9) != 0, int'($urandom_range(32767)) - 16384,
                  3'($urandom), 3'($urandom));
    drain_outputs();
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    stall_req <= stall_req + 1;
    run_clock(40, 7, 0, 0, 10);
    drain_outputs();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 19;
    recv_idle_pct = 65;
    test_directed_edges();
    test_rate_settings(0, 3);

    send_idle_pct = 65;
    recv_idle_pct = 19;
    test_rate_settings(4, 7);
    test_jitter_and_dropout();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_noise();
    test_backpressure();

    drain_outputs();
    repeat (3 * (CNT_W + 3)) @(posedge clk);

    $display("Sent %0d ticks: threshold and window edges, 8 rate/pulse settings, jitter,",
             items_sent);
    $display("dropouts, noise and a long output stall; %0d results, %0d locks, %0d sync losses.",
             results_seen, locks_seen, sync_losses);
    if (mismatches == 0 && pending_outputs.size() == 0) begin
      $display("clock_mult_div_three_channel: match");
    end else begin
      $display("clock_mult_div_three_channel: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("clock_mult_div_three_channel: mismatch");
    $finish;
  end

endmodule
